[rtl/resting_order_fill_matcher_unit_assert.svh]
// Assertion macros shared by the checker of the resting order fill matcher.
// No dependencies; include by bare file name.
`ifndef RESTING_ORDER_FILL_MATCHER_UNIT_ASSERT_SVH
`define RESTING_ORDER_FILL_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define ROMFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("romfm check failed");

// next-cycle implication, off during reset
`define ROMFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("romfm check failed");

// next-cycle implication, always on
`define ROMFM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("romfm check failed");

`endif

[rtl/romfm_pkg.sv]
// Types, constants and codes of the resting order fill matcher.
// No dependencies.
package romfm_pkg;

   localparam int unsigned TableDepthDefault = 64;

   typedef enum logic [1:0] {
      CMD_SUBMIT = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_QUOTE  = 2'd2,
      CMD_TRADE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_SWEEP
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_CANCEL,
      CELL_MARK,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] order_ref;
      logic        order_side;
      logic [31:0] order_price;
      logic [31:0] order_quantity;
      logic [47:0] order_time;
      logic [31:0] bid_tick;
      logic [31:0] bid_depth;
      logic [31:0] ask_tick;
      logic [31:0] ask_depth;
      logic [47:0] quote_time;
      logic [31:0] trade_price;
   } req_type;

   typedef struct packed {
      logic [31:0] fill_order_id;
      logic [47:0] fill_order_time;
      logic [31:0] exec_tick;
      logic [31:0] exec_qty;
      logic        fill_side;
      logic [31:0] fills_total;
      logic [47:0] volume_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [31:0] id;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [47:0] otime;
   } entry_type;

   typedef struct packed {
      logic ins_open;
      logic del_open;
   } cell_link_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
      logic        full;
      logic        any_match;
      logic        is_trade;
      logic [31:0] ask_tick;
      logic [31:0] bid_tick;
      logic [31:0] trade_price;
      entry_type   head_entry;
      logic        head_keep;
   } cell_ctrl_type;

endpackage

[rtl/romfm_stream_if.sv]
// Valid/ready channel interfaces for requests and fills.
// Depends on romfm_pkg.
interface romfm_req_if ();
   logic              valid;
   logic              ready;
   romfm_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface romfm_rsp_if ();
   logic              valid;
   logic              ready;
   romfm_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/romfm_cell.sv]
// One order cell of the id-sorted order chain.
// Depends on romfm_pkg.
module romfm_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  romfm_pkg::cell_ctrl_type ctrl,
   input  romfm_pkg::entry_type     left_entry,
   input  romfm_pkg::entry_type     right_entry,
   input  romfm_pkg::cell_link_type link_prev,
   output romfm_pkg::cell_link_type link_next,
   output romfm_pkg::entry_type     entry,
   output logic                     match
);
   romfm_pkg::entry_type entry_ff, entry_in;
   romfm_pkg::entry_type fresh;
   logic gt, hit_now;

   assign match = entry_ff.valid && (entry_ff.id == ctrl.new_entry.id);
   assign gt = entry_ff.valid && (entry_ff.id > ctrl.new_entry.id);
   assign link_next.ins_open = gt || !entry_ff.valid;
   assign link_next.del_open = match || link_prev.del_open;
   assign entry = entry_ff;

   always_comb begin
      fresh = ctrl.new_entry;
      fresh.valid = 1'b1;
      fresh.hit = 1'b0;
   end

   always_comb begin
      if (ctrl.is_trade) begin
         hit_now = entry_ff.side ? (ctrl.trade_price >= entry_ff.price)
                                 : (ctrl.trade_price <= entry_ff.price);
      end else begin
         hit_now = entry_ff.side ? (entry_ff.price <= ctrl.bid_tick)
                                 : (entry_ff.price >= ctrl.ask_tick);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         romfm_pkg::CELL_HOLD: ;
         romfm_pkg::CELL_WRITE: begin
            if (ctrl.any_match) begin
               if (match) entry_in = fresh;
            end else if (!ctrl.full && link_next.ins_open) begin
               entry_in = link_prev.ins_open ? left_entry : fresh;
            end
         end
         romfm_pkg::CELL_CANCEL: begin
            if (link_next.del_open) entry_in = right_entry;
         end
         romfm_pkg::CELL_MARK: begin
            entry_in.hit = entry_ff.valid && hit_now;
         end
         romfm_pkg::CELL_ROTATE: begin
            if (!right_entry.valid && entry_ff.valid && ctrl.head_keep) begin
               entry_in = ctrl.head_entry;
               entry_in.hit = 1'b0;
            end else begin
               entry_in = right_entry;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         entry_ff.hit <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end
endmodule

[rtl/resting_order_fill_matcher_unit.sv]
// Top level of the resting order fill matcher: command sequencer, quote store,
// totals and fill register around a chain of romfm_cell. Depends on romfm_pkg.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   romfm_pkg::req_type
//   rsp_chan  out  valid/ready   romfm_pkg::rsp_type
//
// Cancel and submit need no sweep, but a submit marks and sweeps when a quote is held.
// Quote and trade mark the resting orders (up to TABLE_DEPTH), then sweep them:
// the chain rotates once via its head cell, one order a cycle if no fill stalls.
// Reset clears the chain valid bits, quote, totals and the fill valid flag.
// A stalled fill register stops the rotation only when the head order fills.
module resting_order_fill_matcher_unit #(
   parameter int unsigned TABLE_DEPTH = romfm_pkg::TableDepthDefault
) (
   input logic         clock,
   input logic         reset,
   romfm_req_if.sink   req_chan,
   romfm_rsp_if.source rsp_chan
);
   localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);

   romfm_pkg::state_type     state_ff, state_in;
   romfm_pkg::cell_ctrl_type ctrl;
   romfm_pkg::entry_type     cells [TABLE_DEPTH+1];
   romfm_pkg::entry_type     lefts [TABLE_DEPTH];
   romfm_pkg::cell_link_type links [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0]   id_eq, hits;

   logic [CountW-1:0] count_ff, count_in, remain_ff, remain_in;
   logic [31:0] bid_tick_ff, bid_depth_ff, ask_tick_ff, ask_depth_ff, trade_price_ff;
   logic [47:0] quote_time_ff;
   logic        is_trade_ff;
   logic [31:0] fills_ff;
   logic [47:0] volume_ff;
   logic [48:0] volume_sum;
   logic        rsp_valid_ff;
   romfm_pkg::rsp_type rsp_ff;

   logic accept, step, emit, head_hit;
   logic [31:0] exec_tick, fill_qty, side_vol;
   romfm_pkg::entry_type head;

   assign req_chan.ready = (state_ff == romfm_pkg::ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign head = cells[0];
   assign head_hit = head.valid && head.hit;
   assign step = (state_ff == romfm_pkg::ST_SWEEP) &&
                 (!head_hit || !rsp_valid_ff || rsp_chan.ready);
   assign emit = step && head_hit;

   assign cells[TABLE_DEPTH] = '0;
   assign links[0] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lefts[i] = '0;
      end else begin : g_rest
         assign lefts[i] = cells[i-1];
      end
      assign hits[i] = cells[i].hit && cells[i].valid;
      romfm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (lefts[i]),
         .right_entry (cells[i+1]),
         .link_prev   (links[i]),
         .link_next   (links[i+1]),
         .entry       (cells[i]),
         .match       (id_eq[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         romfm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (romfm_pkg::cmd_type'(req_chan.payload.cmd))
                  romfm_pkg::CMD_SUBMIT:
                     state_in = (quote_time_ff != '0) ? romfm_pkg::ST_MARK
                                                     : romfm_pkg::ST_IDLE;
                  romfm_pkg::CMD_CANCEL: state_in = romfm_pkg::ST_IDLE;
                  romfm_pkg::CMD_QUOTE, romfm_pkg::CMD_TRADE:
                     state_in = romfm_pkg::ST_MARK;
                  default: state_in = romfm_pkg::ST_IDLE;
               endcase
            end
         end
         romfm_pkg::ST_MARK:
            state_in = (count_ff == '0) ? romfm_pkg::ST_IDLE : romfm_pkg::ST_SWEEP;
         romfm_pkg::ST_SWEEP: begin
            if (step && remain_ff == CountW'(1)) state_in = romfm_pkg::ST_IDLE;
         end
         default: state_in = romfm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.op = romfm_pkg::CELL_HOLD;
      ctrl.new_entry.valid = 1'b1;
      ctrl.new_entry.hit = 1'b0;
      ctrl.new_entry.id = req_chan.payload.order_ref;
      ctrl.new_entry.side = req_chan.payload.order_side;
      ctrl.new_entry.price = req_chan.payload.order_price;
      ctrl.new_entry.quantity = req_chan.payload.order_quantity;
      ctrl.new_entry.otime = req_chan.payload.order_time;
      ctrl.full = (count_ff == CountW'(TABLE_DEPTH));
      ctrl.any_match = |id_eq;
      ctrl.is_trade = is_trade_ff;
      ctrl.ask_tick = ask_tick_ff;
      ctrl.bid_tick = bid_tick_ff;
      ctrl.trade_price = trade_price_ff;
      ctrl.head_entry = head;
      ctrl.head_keep = !head.hit;
      unique case (state_ff)
         romfm_pkg::ST_IDLE: begin
            if (accept && req_chan.payload.cmd == romfm_pkg::CMD_SUBMIT)
               ctrl.op = romfm_pkg::CELL_WRITE;
            else if (accept && req_chan.payload.cmd == romfm_pkg::CMD_CANCEL)
               ctrl.op = romfm_pkg::CELL_CANCEL;
         end
         romfm_pkg::ST_MARK: ctrl.op = romfm_pkg::CELL_MARK;
         romfm_pkg::ST_SWEEP: begin
            if (step) ctrl.op = romfm_pkg::CELL_ROTATE;
         end
         default: ctrl.op = romfm_pkg::CELL_HOLD;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      remain_in = remain_ff;
      if (ctrl.op == romfm_pkg::CELL_WRITE && !ctrl.any_match && !ctrl.full)
         count_in = count_ff + CountW'(1);
      if (ctrl.op == romfm_pkg::CELL_CANCEL && ctrl.any_match)
         count_in = count_ff - CountW'(1);
      if (emit) count_in = count_ff - CountW'(1);
      if (state_ff == romfm_pkg::ST_MARK) remain_in = count_ff;
      if (step) remain_in = remain_ff - CountW'(1);
   end

   always_comb begin
      side_vol = head.side ? bid_depth_ff : ask_depth_ff;
      if (is_trade_ff) begin
         exec_tick = trade_price_ff;
         fill_qty = head.quantity;
      end else begin
         exec_tick = head.side ? bid_tick_ff : ask_tick_ff;
         fill_qty = (head.quantity < side_vol) ? head.quantity : side_vol;
      end
      volume_sum = {1'b0, volume_ff} + {17'd0, fill_qty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= romfm_pkg::ST_IDLE;
         count_ff <= '0;
         remain_ff <= '0;
         bid_tick_ff <= '0;
         bid_depth_ff <= '0;
         ask_tick_ff <= '0;
         ask_depth_ff <= '0;
         quote_time_ff <= '0;
         trade_price_ff <= '0;
         is_trade_ff <= 1'b0;
         fills_ff <= '0;
         volume_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         remain_ff <= remain_in;
         if (accept && req_chan.payload.cmd == romfm_pkg::CMD_QUOTE) begin
            bid_tick_ff <= req_chan.payload.bid_tick;
            bid_depth_ff <= req_chan.payload.bid_depth;
            ask_tick_ff <= req_chan.payload.ask_tick;
            ask_depth_ff <= req_chan.payload.ask_depth;
            quote_time_ff <= req_chan.payload.quote_time;
         end
         if (accept && req_chan.payload.cmd == romfm_pkg::CMD_TRADE)
            trade_price_ff <= req_chan.payload.trade_price;
         if (accept) is_trade_ff <= (req_chan.payload.cmd == romfm_pkg::CMD_TRADE);
         if (emit) begin
            if (fills_ff != '1) fills_ff <= fills_ff + 32'd1;
            volume_ff <= volume_sum[48] ? '1 : volume_sum[47:0];
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.fill_order_id <= head.id;
         rsp_ff.fill_order_time <= head.otime;
         rsp_ff.exec_tick <= exec_tick;
         rsp_ff.exec_qty <= fill_qty;
         rsp_ff.fill_side <= head.side;
         rsp_ff.fills_total <= (fills_ff != '1) ? fills_ff + 32'd1 : fills_ff;
         rsp_ff.volume_total <= volume_sum[48] ? '1 : volume_sum[47:0];
         rsp_ff.last <= ~|hits[TABLE_DEPTH-1:1];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule

[rtl/romfm_checker.sv]
// Port-level checks of the resting order fill matcher, bound to its top level.
// Depends on resting_order_fill_matcher_unit_assert.svh.
`include "resting_order_fill_matcher_unit_assert.svh"

module romfm_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   `ROMFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ROMFM_ASSERT_NOW(a_busy_mid_burst, clock, reset, rsp_valid && !rsp_last, !req_ready)
   `ROMFM_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
endmodule

bind resting_order_fill_matcher_unit romfm_checker u_romfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.payload.last)
);

[bench/romfm_tb_if.sv]
`timescale 1ns / 1ps
// Bench package of the resting order fill matcher: the expected-fill record.
// No dependencies.
package romfm_tb_pkg;
   typedef struct {
      logic [31:0] id;
      logic [47:0] otime;
      logic [31:0] price;
      logic [31:0] qty;
      logic        side;
      logic [31:0] fills;
      logic [47:0] volume;
      logic        last;
   } fill_type;
endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Bench for resting_order_fill_matcher_unit: drives submits, cancels, quotes and
// trades, predicts fills with a local order table, and checks every fill in order.
// Depends on romfm_pkg, romfm_tb_pkg and the RTL channel interfaces.
module tb_top;
   localparam int Depth = romfm_pkg::TableDepthDefault;
   localparam int WatchLimit = 20000;

   logic clock;
   logic reset;
   romfm_req_if req_chan ();
   romfm_rsp_if rsp_chan ();

   resting_order_fill_matcher_unit #(.TABLE_DEPTH(Depth)) i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   logic        book_valid [Depth];
   logic [31:0] book_id [Depth];
   logic        book_side [Depth];
   logic [31:0] book_price [Depth];
   logic [31:0] book_qty [Depth];
   logic [47:0] book_time [Depth];
   logic [31:0] bid_px, bid_vol, ask_px, ask_vol;
   logic [47:0] quote_stamp;
   logic [31:0] fill_count;
   logic [47:0] volume_sum;
   romfm_tb_pkg::fill_type pending_fills [$];
   int          errors = 0;
   int          idle_in = 0, stall_out = 0;
   int          quiet = 0;
   logic [31:0] id_pool [8];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void predict_fills(romfm_pkg::req_type r);
      bit          hit [Depth];
      logic [31:0] hp [Depth], hq [Depth];
      int          slot, best, n;
      romfm_tb_pkg::fill_type f;
      slot = -1;
      n = 0;
      for (int i = 0; i < Depth; i++) hit[i] = 1'b0;
      case (romfm_pkg::cmd_type'(r.cmd))
         romfm_pkg::CMD_SUBMIT: begin
            for (int i = 0; i < Depth && slot < 0; i++)
               if (book_valid[i] && book_id[i] == r.order_ref) slot = i;
            for (int i = 0; i < Depth && slot < 0; i++)
               if (!book_valid[i]) slot = i;
            if (slot >= 0) begin
               book_valid[slot] = 1'b1;
               book_id[slot] = r.order_ref;
               book_side[slot] = r.order_side;
               book_price[slot] = r.order_price;
               book_qty[slot] = r.order_quantity;
               book_time[slot] = r.order_time;
            end
         end
         romfm_pkg::CMD_CANCEL: begin
            for (int i = 0; i < Depth; i++)
               if (book_valid[i] && book_id[i] == r.order_ref) book_valid[i] = 1'b0;
         end
         romfm_pkg::CMD_QUOTE: begin
            bid_px = r.bid_tick;
            bid_vol = r.bid_depth;
            ask_px = r.ask_tick;
            ask_vol = r.ask_depth;
            quote_stamp = r.quote_time;
         end
         default: ;
      endcase
      for (int i = 0; i < Depth; i++) begin
         if (!book_valid[i]) continue;
         if (r.cmd == romfm_pkg::CMD_TRADE) begin
            if ((!book_side[i] && r.trade_price <= book_price[i]) ||
                (book_side[i] && r.trade_price >= book_price[i])) begin
               hit[i] = 1'b1;
               hp[i] = r.trade_price;
               hq[i] = book_qty[i];
            end
         end else if (r.cmd == romfm_pkg::CMD_QUOTE ||
                      (r.cmd == romfm_pkg::CMD_SUBMIT && quote_stamp != '0)) begin
            if (!book_side[i] && book_price[i] >= ask_px) begin
               hit[i] = 1'b1;
               hp[i] = ask_px;
               hq[i] = book_qty[i] < ask_vol ? book_qty[i] : ask_vol;
            end else if (book_side[i] && book_price[i] <= bid_px) begin
               hit[i] = 1'b1;
               hp[i] = bid_px;
               hq[i] = book_qty[i] < bid_vol ? book_qty[i] : bid_vol;
            end
         end
      end
      forever begin
         best = -1;
         for (int i = 0; i < Depth; i++)
            if (hit[i] && (best < 0 || book_id[i] < book_id[best])) best = i;
         if (best < 0) break;
         hit[best] = 1'b0;
         book_valid[best] = 1'b0;
         if (fill_count != 32'hFFFF_FFFF) fill_count++;
         if ({1'b0, volume_sum} + hq[best] > 49'hFFFF_FFFF_FFFF) volume_sum = '1;
         else volume_sum = volume_sum + hq[best];
         f.id = book_id[best];
         f.otime = book_time[best];
         f.price = hp[best];
         f.qty = hq[best];
         f.side = book_side[best];
         f.fills = fill_count;
         f.volume = volume_sum;
         f.last = 1'b0;
         pending_fills = {pending_fills, f};
         n++;
      end
      if (n > 0) pending_fills[$].last = 1'b1;
   endfunction

   function automatic romfm_pkg::req_type make_req(romfm_pkg::cmd_type c, logic [31:0] id,
                                                   logic side, logic [31:0] px,
                                                   logic [31:0] qty);
      romfm_pkg::req_type r;
      r = '0;
      r.cmd = c;
      r.order_ref = id;
      r.order_side = side;
      r.order_price = px;
      r.order_quantity = qty;
      r.order_time = 48'({$urandom, $urandom});
      r.trade_price = px;
      return r;
   endfunction

   function automatic romfm_pkg::req_type make_quote(logic [31:0] bp, logic [31:0] bv,
                                                     logic [31:0] ap, logic [31:0] av,
                                                     logic [47:0] t);
      romfm_pkg::req_type r;
      r = '0;
      r.cmd = romfm_pkg::CMD_QUOTE;
      r.bid_tick = bp;
      r.bid_depth = bv;
      r.ask_tick = ap;
      r.ask_depth = av;
      r.quote_time = t;
      return r;
   endfunction

   function automatic romfm_pkg::req_type random_req();
      romfm_pkg::req_type r;
      int      pick;
      logic [31:0] base;
      pick = $urandom_range(0, 99);
      base = ($urandom_range(0, 9) == 0) ? $urandom : 32'd1000;
      r = make_req(romfm_pkg::CMD_SUBMIT,
                   ($urandom_range(0, 5) == 0) ? $urandom : id_pool[$urandom_range(0, 7)],
                   1'($urandom_range(0, 1)), base + $urandom_range(0, 40) - 20,
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500));
      if (pick < 55) r.cmd = romfm_pkg::CMD_SUBMIT;
      else if (pick < 70) r.cmd = romfm_pkg::CMD_CANCEL;
      else if (pick < 85) begin
         r = make_quote(base + $urandom_range(0, 20) - 25, $urandom_range(0, 300),
                        base + $urandom_range(0, 20) + 5, $urandom_range(0, 300),
                        ($urandom_range(0, 7) == 0) ? 48'd0 : 48'({$urandom, $urandom}));
         if ($urandom_range(0, 9) == 0) begin
            r.bid_tick = $urandom; r.ask_tick = $urandom;
            r.bid_depth = $urandom; r.ask_depth = $urandom;
         end
      end else begin
         r.cmd = romfm_pkg::CMD_TRADE;
         r.trade_price = ($urandom_range(0, 9) == 0) ? $urandom
                                                     : base + $urandom_range(0, 40) - 20;
      end
      return r;
   endfunction

   task automatic send(romfm_pkg::req_type r);
      while ($urandom_range(0, 99) < idle_in) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_fills(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_fills.size() != 0) @(negedge clock);
      repeat (Depth + 8) @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_out);

   always @(posedge clock) begin
      romfm_tb_pkg::fill_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_fills.size() == 0) begin
            $display("%0t unexpected fill: expected none, actual %p", $time, rsp_chan.payload);
            errors++;
         end else begin
            e = pending_fills.pop_front();
            if (rsp_chan.payload.fill_order_id !== e.id ||
                rsp_chan.payload.fill_order_time !== e.otime ||
                rsp_chan.payload.exec_tick !== e.price || rsp_chan.payload.exec_qty !== e.qty ||
                rsp_chan.payload.fill_side !== e.side || rsp_chan.payload.fills_total !== e.fills ||
                rsp_chan.payload.volume_total !== e.volume || rsp_chan.payload.last !== e.last)
            begin
               $display("%0t fill mismatch: expected %p, actual %p", $time, e, rsp_chan.payload);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      romfm_pkg::req_type directed [16];
      int      phase;
      for (int i = 0; i < Depth; i++) book_valid[i] = 1'b0;
      bid_px = '0; bid_vol = '0; ask_px = '0; ask_vol = '0; quote_stamp = '0;
      fill_count = '0; volume_sum = '0;
      for (int i = 0; i < 8; i++) id_pool[i] = (i == 7) ? 32'hFFFF_FFFF : i * 3;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed[0] = make_req(romfm_pkg::CMD_TRADE, 0, 1'b0, 0, 0);
      directed[1] = make_req(romfm_pkg::CMD_SUBMIT, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF);
      directed[2] = make_req(romfm_pkg::CMD_SUBMIT, 0, 1'b1, 0, 0);
      directed[3] = make_req(romfm_pkg::CMD_SUBMIT, 5, 1'b0, 100, 10);
      directed[4] = make_req(romfm_pkg::CMD_SUBMIT, 5, 1'b1, 200, 20);
      directed[5] = make_req(romfm_pkg::CMD_CANCEL, 5, 1'b0, 0, 0);
      directed[6] = make_req(romfm_pkg::CMD_CANCEL, 77, 1'b0, 0, 0);
      directed[7] = make_req(romfm_pkg::CMD_SUBMIT, 9, 1'b0, 150, 40);
      directed[8] = make_req(romfm_pkg::CMD_SUBMIT, 8, 1'b1, 90, 7);
      directed[9] = make_quote(100, 5, 150, 30, 48'hFFFF_FFFF_FFFF);
      directed[10] = make_req(romfm_pkg::CMD_SUBMIT, 3, 1'b0, 160, 12);
      directed[11] = make_req(romfm_pkg::CMD_SUBMIT, 4, 1'b0, 10, 12);
      directed[12] = make_quote(0, 0, 32'hFFFF_FFFF, 0, 48'd0);
      directed[13] = make_req(romfm_pkg::CMD_SUBMIT, 2, 1'b1, 50, 3);
      directed[14] = make_req(romfm_pkg::CMD_TRADE, 0, 1'b0, 32'hFFFF_FFFF, 0);
      directed[15] = make_req(romfm_pkg::CMD_TRADE, 0, 1'b0, 0, 0);
      foreach (directed[i]) send(directed[i]);
      wait_drained();
      for (int i = 0; i < Depth + 2; i++)
         send(make_req(romfm_pkg::CMD_SUBMIT, 32'h1000 + i, 1'(i % 2), 500, $urandom));
      send(make_req(romfm_pkg::CMD_TRADE, 0, 1'b0, 500, 0));
      send(make_req(romfm_pkg::CMD_SUBMIT, 32'h8000_0000, 1'b0, 1, 32'hFFFF_FFFF));
      send(make_req(romfm_pkg::CMD_TRADE, 0, 1'b0, 1, 0));
      wait_drained();

      for (int i = 0; i < 345; i++) begin
         phase = (i / 40) % 4;
         idle_in = (phase == 1 || phase == 3) ? 68 : 0;
         stall_out = (phase == 2) ? 68 : (phase == 3) ? 19 : 0;
         if (phase == 3) idle_in = 19;
         if (i == 200) wait_drained();
         send(random_req());
      end
      idle_in = 0;
      stall_out = 0;
      wait_drained();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/romfm_pkg.sv
rtl/romfm_stream_if.sv
rtl/romfm_cell.sv
rtl/resting_order_fill_matcher_unit.sv
rtl/romfm_checker.sv
bench/romfm_tb_if.sv
bench/tb_top.sv
